FILE: hdl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // fixed field widths
    localparam int SYM_W      = 8;
    localparam int CODE_IN_W  = 16;
    localparam int LEN_IN_W   = 5;
    localparam int WORD_OUT_W = 16;
    localparam int TOTAL_W    = 32;

    // result queue sizing
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // input transaction
    typedef struct packed {
        logic [1:0]           cmd;
        logic [SYM_W-1:0]     symbol;
        logic [CODE_IN_W-1:0] code_bits;
        logic [LEN_IN_W-1:0]  code_len;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [WORD_OUT_W-1:0] packed_word;
        logic [TOTAL_W-1:0]    total_bits;
        logic                  is_count;
        logic                  last;
    } t_out_item;

    // control of the lookup stage towards the packer
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
    } t_s1_ctrl;

endpackage

FILE: hdl/hcbp_lookup.sv
// ----------------------------------------------------------------------------
// hcbp_lookup
// code table memory with per-entry valid bits and the input register stage
// ----------------------------------------------------------------------------
module hcbp_lookup #(
    parameter int TABLE_ENTRIES = 256,
    parameter int LEN_LIMIT     = 16,
    parameter int LEN_W         = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  hcbp_pkg::t_in_item       i_item,
    input  logic                     i_take,
    output hcbp_pkg::t_s1_ctrl       o_ctrl,
    output logic [LEN_LIMIT-1:0]     o_code,
    output logic [LEN_W-1:0]         o_clen
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [LEN_LIMIT-1:0] r_mem_code [TABLE_ENTRIES];
    logic [LEN_W-1:0]     r_mem_len  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [LEN_W-1:0]     len_sat;
    logic [LEN_LIMIT-1:0] mask;
    logic [LEN_LIMIT-1:0] code_wr;
    logic                 do_load;

    logic                 r_s1_valid;
    logic [1:0]           r_s1_cmd;
    logic                 r_hit;
    logic [LEN_LIMIT-1:0] r_rd_code;
    logic [LEN_W-1:0]     r_rd_len;

    // address decode and range check
    assign in_range = ({1'b0, i_item.symbol} < 9'(TABLE_ENTRIES));
    assign idx      = i_item.symbol[IDX_W-1:0];
    assign do_load  = i_accept && (i_item.cmd == hcbp_pkg::CMD_LOAD) && in_range;

    // length saturation and code masking for a load
    always_comb begin
        len_sat = ({1'b0, i_item.code_len} > 6'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                            : LEN_W'(i_item.code_len);
        for (int b = 0; b < LEN_LIMIT; b++) begin
            mask[b] = (LEN_W'(b) < len_sat);
        end
        code_wr = LEN_LIMIT'(i_item.code_bits) & mask;
    end

    // table memory, written and read on accepted transactions
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem_code[idx] <= code_wr;
            r_mem_len[idx]  <= len_sat;
        end
        if (i_accept) begin
            r_rd_code <= r_mem_code[idx];
            r_rd_len  <= r_mem_len[idx];
        end
    end

    // valid bits, cleared at reset so unwritten entries read as zero length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_load) begin
            r_valid[idx] <= 1'b1;
        end
    end

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_cmd <= i_item.cmd;
            r_hit    <= in_range && r_valid[idx];
        end
    end

    // lookup results to the packer
    assign o_ctrl.valid = r_s1_valid;
    assign o_ctrl.cmd   = r_s1_cmd;
    assign o_code       = r_hit ? r_rd_code : '0;
    assign o_clen       = r_hit ? r_rd_len : '0;

endmodule

FILE: hdl/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// word accumulator, bit position and bit total with result generation
// ----------------------------------------------------------------------------
module hcbp_packer #(
    parameter int WORD_BITS = 16,
    parameter int LEN_LIMIT = 16,
    parameter int LEN_W     = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  hcbp_pkg::t_s1_ctrl   i_ctrl,
    input  logic [LEN_LIMIT-1:0] i_code,
    input  logic [LEN_W-1:0]     i_clen,
    output logic [1:0]           o_push_n,
    output hcbp_pkg::t_out_item  o_res0,
    output hcbp_pkg::t_out_item  o_res1
);

    localparam int POS_W = $clog2(WORD_BITS);
    localparam int SUM_W = POS_W + 1;

    logic [WORD_BITS-1:0]         r_acc, n_acc;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [hcbp_pkg::TOTAL_W-1:0] r_total, n_total;

    logic [2*WORD_BITS-1:0] wide;
    logic [SUM_W-1:0]       sum;
    logic                   full;

    // merge the code into the current word
    assign wide = {{WORD_BITS{1'b0}}, r_acc} | ((2*WORD_BITS)'(i_code) << r_pos);
    assign sum  = SUM_W'(r_pos) + SUM_W'(i_clen);
    assign full = (sum >= SUM_W'(WORD_BITS));

    // next state and results
    always_comb begin
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_total  = r_total;
        o_push_n = 2'd0;
        o_res0   = '0;
        o_res1   = '0;
        if (i_fire) begin
            unique case (i_ctrl.cmd)
                hcbp_pkg::CMD_ENCODE: begin
                    n_total = r_total + hcbp_pkg::TOTAL_W'(i_clen);
                    if (full) begin
                        o_push_n           = 2'd1;
                        o_res0.packed_word = hcbp_pkg::WORD_OUT_W'(wide[WORD_BITS-1:0]);
                        n_acc              = wide[2*WORD_BITS-1:WORD_BITS];
                        n_pos              = POS_W'(sum - SUM_W'(WORD_BITS));
                    end else begin
                        n_acc = wide[WORD_BITS-1:0];
                        n_pos = POS_W'(sum);
                    end
                end
                hcbp_pkg::CMD_FLUSH: begin
                    o_push_n           = 2'd2;
                    o_res0.packed_word = hcbp_pkg::WORD_OUT_W'(r_acc);
                    o_res1.total_bits  = r_total;
                    o_res1.is_count    = 1'b1;
                    o_res1.last        = 1'b1;
                    n_acc              = '0;
                    n_pos              = '0;
                    n_total            = '0;
                end
                default: begin
                    // load and the unused code leave the stream alone
                end
            endcase
        end
    end

    // stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_total <= '0;
        end else begin
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_total <= n_total;
        end
    end

endmodule

FILE: hdl/hcbp_out_fifo.sv
// ----------------------------------------------------------------------------
// hcbp_out_fifo
// small result queue taking up to two transactions per cycle
// ----------------------------------------------------------------------------
module hcbp_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_n,
    input  hcbp_pkg::t_out_item i_res0,
    input  hcbp_pkg::t_out_item i_res1,
    output logic                o_room2,
    output logic                o_valid,
    input  logic                i_ready,
    output hcbp_pkg::t_out_item o_item
);

    hcbp_pkg::t_out_item r_buf [hcbp_pkg::OUT_DEPTH];

    logic [hcbp_pkg::OUT_PTR_W-1:0] r_wp, r_rp;
    logic [hcbp_pkg::OUT_CNT_W-1:0] r_cnt, n_cnt;
    logic                           pop;

    // status
    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= hcbp_pkg::OUT_CNT_W'(hcbp_pkg::OUT_DEPTH - 2));
    assign o_item  = r_buf[r_rp];
    assign pop     = o_valid && i_ready;
    assign n_cnt   = r_cnt + hcbp_pkg::OUT_CNT_W'(i_push_n) - hcbp_pkg::OUT_CNT_W'(pop);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_buf[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_buf[r_wp + 1'b1] <= i_res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + hcbp_pkg::OUT_PTR_W'(i_push_n);
            r_rp  <= r_rp + hcbp_pkg::OUT_PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: hdl/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// table-driven huffman encoder packing code bits into words
// ----------------------------------------------------------------------------
// Input transactions carry a command: load writes one code table entry, encode
// looks up a byte symbol and appends its code least significant bit first to
// the current word, flush emits the current word and then the bit count
// (is_count and last set) and clears the stream. Both channels are valid/ready.
// A result passes the registered table read and then the word merge, which
// writes it into the result queue in front of the output.
// Throughput: one input transaction per cycle while the result queue has room
// for two results; an encode gives at most one result, a flush gives two, and
// the output port moves one result per cycle, so a run of flushes is slowed.
// A four-entry result queue sits between the merge stage and the output, so
// input is still taken while a result waits; when the receiver stalls and the
// queue cannot take two more results, the merge stage holds and input ready
// drops.
// Reset clears the stream state, the result queue and the table valid bits;
// all table entries then read as zero length. No clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_BITS = 16,
    parameter int WORD_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcbp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcbp_pkg::t_out_item o_out_item
);

    localparam int LEN_LIMIT = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
    localparam int LEN_W     = $clog2(LEN_LIMIT + 1);

    hcbp_pkg::t_s1_ctrl   s1_ctrl;
    logic [LEN_LIMIT-1:0] s1_code;
    logic [LEN_W-1:0]     s1_clen;
    logic                 accept;
    logic                 fire;
    logic                 room2;
    logic [1:0]           push_n;
    hcbp_pkg::t_out_item  res0, res1;

    // handshake
    assign fire       = s1_ctrl.valid && room2;
    assign o_in_ready = !s1_ctrl.valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    // table lookup stage
    hcbp_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LEN_LIMIT     (LEN_LIMIT),
        .LEN_W         (LEN_W)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_take   (fire),
        .o_ctrl   (s1_ctrl),
        .o_code   (s1_code),
        .o_clen   (s1_clen)
    );

    // word merge stage
    hcbp_packer #(
        .WORD_BITS (WORD_BITS),
        .LEN_LIMIT (LEN_LIMIT),
        .LEN_W     (LEN_W)
    ) u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_ctrl   (s1_ctrl),
        .i_code   (s1_code),
        .i_clen   (s1_clen),
        .o_push_n (push_n),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    // result queue
    hcbp_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_room2  (room2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (o_out_item)
    );

endmodule

FILE: hdl/hcbp_checker.sv
// ----------------------------------------------------------------------------
// hcbp_checker
// port-level checks of the huffman code bit packer
// ----------------------------------------------------------------------------
module hcbp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hcbp_pkg::t_out_item o_out_item
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction changed while stalled");

    // a count result always closes a flush and carries no word
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_count |->
            o_out_item.last && (o_out_item.packed_word == '0))
        else $error("count result without last or with a word");

    // a word result carries no count and never closes a flush
    a_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_count |->
            !o_out_item.last && (o_out_item.total_bits == '0))
        else $error("word result with count fields set");

    // after reset the block is empty and ready for input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
